// File: sv/frame_min_max_peak_stats_assert.svh
// Assertion macros shared by the frame statistics modules.
`ifndef FRAME_MIN_MAX_PEAK_STATS_ASSERT_SVH
`define FRAME_MIN_MAX_PEAK_STATS_ASSERT_SVH
`ifndef ASSERT_OFF
// Check that cons follows ante in the same cycle.
`define FMMPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check that cons holds in the cycle after ante.
`define FMMPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FMMPS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define FMMPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: sv/fmmps_pkg.sv
// Shared constants and types for the frame min/max/peak statistics block.
package fmmps_pkg;

	localparam int SAMPLE_W  = 12;
	localparam int CNT_W     = 9;
	localparam int AMP_W     = 17;
	localparam int DIV_STEPS = AMP_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam logic [CNT_W-1:0]    MAX_FRAME = 9'd256;
	localparam logic [AMP_W-1:0]    AMP_MAX   = 17'h1FFFF;
	localparam logic [SAMPLE_W-1:0] ZP_RESET  = 12'd2048;
	localparam logic [SAMPLE_W-1:0] MIN_RESET = 12'hFFF;
	localparam logic [SAMPLE_W-1:0] MAX_RESET = 12'h000;

	localparam int ADDR_W = 3;
	localparam logic [0:0] REG_ZERO_POINT = 1'b0;

	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 64;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic sample_en;
		logic start;
		logic step;
		logic load;
	} cmd_t;

endpackage

// File: sv/fmmps_ctrl.sv
// Controller: frame sequencing, divider step count and output valid.
`include "frame_min_max_peak_stats_assert.svh"
module fmmps_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tlast,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	output fmmps_pkg::cmd_t     cmd
);

	typedef enum logic [1:0] {ST_IDLE, ST_LEVEL, ST_DIV, ST_DONE} state_t;

	state_t                          state_q;
	logic [fmmps_pkg::STEP_W-1:0]    step_cnt_q;
	logic                            out_valid_q;
	logic                            accept;

	// Take items only while no frame end is being processed
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	// Decode commands from state
	always_comb begin
		cmd.sample_en = accept;
		cmd.start     = (state_q == ST_LEVEL);
		cmd.step      = (state_q == ST_DIV);
		cmd.load      = (state_q == ST_DONE) && (!out_valid_q || m_tready);
	end

	// Hold state, step count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && s_tlast) begin
						state_q <= ST_LEVEL;
					end
				end
				ST_LEVEL: begin
					step_cnt_q <= fmmps_pkg::STEP_W'(fmmps_pkg::DIV_STEPS - 1);
					state_q    <= ST_DIV;
				end
				ST_DIV: begin
					if (step_cnt_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						step_cnt_q <= step_cnt_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (cmd.load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`FMMPS_ASSERT_NEXT(a_last_stalls, clk, arst_n, accept && s_tlast, !s_tready, "frame end did not stall input")
	`FMMPS_ASSERT_IMPLY(a_step_range, clk, arst_n, state_q == ST_DIV, step_cnt_q <= fmmps_pkg::STEP_W'(fmmps_pkg::DIV_STEPS - 1), "divider step count out of range")
	`FMMPS_ASSERT_NEXT(a_load_valid, clk, arst_n, cmd.load, m_tvalid, "loaded result not presented")

endmodule

// File: sv/fmmps_dp.sv
// Datapath: running min/max and counts, amplitude divider, result register.
`include "frame_min_max_peak_stats_assert.svh"
module fmmps_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fmmps_pkg::cmd_t                     cmd,
	input  logic [fmmps_pkg::SAMPLE_W-1:0]      sample,
	input  logic [fmmps_pkg::SAMPLE_W-1:0]      zero_point,
	output logic [fmmps_pkg::SAMPLE_W-1:0]      min_sample,
	output logic [fmmps_pkg::SAMPLE_W-1:0]      max_sample,
	output logic [fmmps_pkg::CNT_W-1:0]         above_count,
	output logic [fmmps_pkg::CNT_W-1:0]         below_count,
	output logic [fmmps_pkg::AMP_W-1:0]         amplitude
);

	logic [fmmps_pkg::SAMPLE_W-1:0] run_min_q, run_max_q;
	logic [fmmps_pkg::CNT_W-1:0]    above_q, below_q;
	logic [fmmps_pkg::SAMPLE_W-1:0] zp_q, rem_q;
	logic                           nbit_q, ovf_q, zero_q;
	logic [fmmps_pkg::AMP_W-1:0]    quot_q;

	logic [fmmps_pkg::SAMPLE_W-1:0] up, dn, level;
	logic [fmmps_pkg::SAMPLE_W:0]   trial;
	logic                           fits;

	// Larger excursion from the zero point, clamped at zero
	always_comb begin
		up    = (run_max_q > zero_point) ? run_max_q - zero_point : '0;
		dn    = (zero_point > run_min_q) ? zero_point - run_min_q : '0;
		level = (up > dn) ? up : dn;
	end

	// One restoring division step
	assign trial = {rem_q, nbit_q};
	assign fits  = (trial >= {1'b0, zp_q});

	// Track frame statistics; restart after the result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_q <= fmmps_pkg::MIN_RESET;
			run_max_q <= fmmps_pkg::MAX_RESET;
			above_q   <= '0;
			below_q   <= '0;
		end else if (cmd.load) begin
			run_min_q <= fmmps_pkg::MIN_RESET;
			run_max_q <= fmmps_pkg::MAX_RESET;
			above_q   <= '0;
			below_q   <= '0;
		end else if (cmd.sample_en) begin
			if (sample > run_max_q) begin
				run_max_q <= sample;
			end
			if (sample < run_min_q) begin
				run_min_q <= sample;
			end
			if (sample > zero_point) begin
				if (above_q < fmmps_pkg::MAX_FRAME) begin
					above_q <= above_q + 1'b1;
				end
			end else begin
				if (below_q < fmmps_pkg::MAX_FRAME) begin
					below_q <= below_q + 1'b1;
				end
			end
		end
	end

	// Divide level * 2^16 by the zero point, one quotient bit per step
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			zp_q   <= zero_point;
			rem_q  <= level >> 1;
			nbit_q <= level[0];
			ovf_q  <= ({1'b0, level} >= {zero_point, 1'b0});
			zero_q <= (level == '0);
			quot_q <= '0;
		end else if (cmd.step) begin
			rem_q  <= fits ? fmmps_pkg::SAMPLE_W'(trial - {1'b0, zp_q})
			               : fmmps_pkg::SAMPLE_W'(trial);
			nbit_q <= 1'b0;
			quot_q <= {quot_q[fmmps_pkg::AMP_W-2:0], fits};
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			min_sample  <= run_min_q;
			max_sample  <= run_max_q;
			above_count <= above_q;
			below_count <= below_q;
			if (zero_q) begin
				amplitude <= '0;
			end else if (ovf_q) begin
				amplitude <= fmmps_pkg::AMP_MAX;
			end else begin
				amplitude <= quot_q;
			end
		end
	end

	`FMMPS_ASSERT_IMPLY(a_rem_below_div, clk, arst_n, cmd.step && !ovf_q && !zero_q, rem_q < zp_q, "divider remainder not below divisor")
	`FMMPS_ASSERT_IMPLY(a_min_le_max, clk, arst_n, cmd.load, run_min_q <= run_max_q, "frame min above max at result load")
	`FMMPS_ASSERT_NEXT(a_stats_cleared, clk, arst_n, cmd.load, (above_q == '0) && (below_q == '0), "counts not restarted after frame")

endmodule

// File: sv/frame_min_max_peak_stats.sv
// Top level: frame min/max/peak statistics with stream ports and APB register.
//
//  port group  | dir | fields (low bit up)
//  s_*         | in  | tdata: sample[11:0], pad[15:12]; tlast: last
//  m_*         | out | tdata: min_sample, max_sample, above_count, below_count,
//              |     |        amplitude, pad[63:59]
//  APB         | in  | addr 0: zero_point[11:0]
//
// A sample without tlast is accepted while idle; the next can follow directly.
// A sample with tlast goes through accept, level compute, 17 steps of the
// restoring divider for the Q1.16 amplitude, then the result register load.
// The result register holds a result until taken; samples of the next frame
// are accepted meanwhile, and the load waits only while a held result is not taken.
// After reset zero_point is 2048, min is 4095, max and both counts are 0.
module frame_min_max_peak_stats (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [fmmps_pkg::IN_TDATA_W-1:0]       s_tdata,  // sample[11:0]
	input  logic                                   s_tlast,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// min_sample[11:0], max_sample[23:12], above_count[32:24],
	// below_count[41:33], amplitude[58:42]
	output logic [fmmps_pkg::OUT_TDATA_W-1:0]      m_tdata,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [fmmps_pkg::ADDR_W-1:0]           paddr,
	input  logic [31:0]                            pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready
);

	fmmps_pkg::cmd_t                    cmd;
	logic [fmmps_pkg::SAMPLE_W-1:0]     zero_point_q;
	logic [fmmps_pkg::SAMPLE_W-1:0]     min_sample, max_sample;
	logic [fmmps_pkg::CNT_W-1:0]        above_count, below_count;
	logic [fmmps_pkg::AMP_W-1:0]        amplitude;
	logic                               reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[fmmps_pkg::ADDR_W-1:2] == fmmps_pkg::REG_ZERO_POINT);

	// Write the zero point register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_point_q <= fmmps_pkg::ZP_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			zero_point_q <= pwdata[fmmps_pkg::SAMPLE_W-1:0];
		end
	end

	// Read back the register
	assign prdata = reg_hit ? {20'd0, zero_point_q} : 32'd0;

	fmmps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	fmmps_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sample      (s_tdata[fmmps_pkg::SAMPLE_W-1:0]),
		.zero_point  (zero_point_q),
		.min_sample  (min_sample),
		.max_sample  (max_sample),
		.above_count (above_count),
		.below_count (below_count),
		.amplitude   (amplitude)
	);

	// Pack the result item
	assign m_tdata = {5'd0, amplitude, below_count, above_count, max_sample, min_sample};

endmodule

// File: dv/frame_min_max_peak_stats_tb.sv
// Self-checking testbench for frame_min_max_peak_stats: directed rows, then random frames.
`timescale 1ns / 1ps

module frame_min_max_peak_stats_tb;

	localparam int SAMPLE_W    = fmmps_pkg::SAMPLE_W;
	localparam int CNT_W       = fmmps_pkg::CNT_W;
	localparam int AMP_W       = fmmps_pkg::AMP_W;
	localparam int ADDR_W      = fmmps_pkg::ADDR_W;
	localparam int IN_TDATA_W  = fmmps_pkg::IN_TDATA_W;
	localparam int OUT_TDATA_W = fmmps_pkg::OUT_TDATA_W;

	localparam logic [0:0]          REG_ZERO_POINT = fmmps_pkg::REG_ZERO_POINT;
	localparam logic [CNT_W-1:0]    MAX_FRAME      = fmmps_pkg::MAX_FRAME;
	localparam logic [AMP_W-1:0]    AMP_MAX        = fmmps_pkg::AMP_MAX;
	localparam logic [SAMPLE_W-1:0] ZP_RESET       = fmmps_pkg::ZP_RESET;
	localparam logic [SAMPLE_W-1:0] MIN_RESET      = fmmps_pkg::MIN_RESET;
	localparam logic [SAMPLE_W-1:0] MAX_RESET      = fmmps_pkg::MAX_RESET;

	localparam int SETTLE_CYCLES  = 24;    // margin for a frame end to pass through the block
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 183;
	localparam int PHASES         = 6;

	localparam logic [ADDR_W-1:0] ZP_ADDR    = ADDR_W'(4 * REG_ZERO_POINT);
	localparam logic [ADDR_W-1:0] SPARE_ADDR = ADDR_W'(4);

	typedef struct packed {
		logic [SAMPLE_W-1:0] min_s;
		logic [SAMPLE_W-1:0] max_s;
		logic [CNT_W-1:0]    above_n;
		logic [CNT_W-1:0]    below_n;
		logic [AMP_W-1:0]    amp;
	} frame_stats_t;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		logic [ADDR_W-1:0]   addr;
		logic [31:0]         wdata;
		logic [SAMPLE_W-1:0] smp;
		logic                lst;
		logic                pinned;
		frame_stats_t        want;
	} bringup_row_t;

	typedef struct {
		logic         pinned;
		frame_stats_t want;
	} sample_tag_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // sample[11:0], pad[15:12]
	logic                   s_tlast;
	logic                   m_tvalid;
	logic                   m_tready;
	// min_sample[11:0], max_sample[23:12], above_count[32:24],
	// below_count[41:33], amplitude[58:42], pad[63:59]
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [ADDR_W-1:0]      paddr;
	logic [31:0]            pwdata;
	logic [31:0]            prdata;
	logic                   pready;

	frame_min_max_peak_stats dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Shadow of the block: zero point and running frame statistics
	logic [SAMPLE_W-1:0] zp_shadow   = ZP_RESET;
	logic [SAMPLE_W-1:0] track_min   = MIN_RESET;
	logic [SAMPLE_W-1:0] track_max   = MAX_RESET;
	logic [CNT_W-1:0]    above_total = '0;
	logic [CNT_W-1:0]    below_total = '0;

	frame_stats_t pending_stats[$];
	sample_tag_t  sent_tags[$];
	bringup_row_t bringup[$];

	int unsigned fault_count   = 0;
	int unsigned quiet_cycles  = 0;
	int unsigned send_idle_pct = 0;
	int unsigned take_idle_pct = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic frame_stats_t stats(int mn, int mx, int ab, int bl, int amp);
		frame_stats_t r;
		r.min_s   = SAMPLE_W'(mn);
		r.max_s   = SAMPLE_W'(mx);
		r.above_n = CNT_W'(ab);
		r.below_n = CNT_W'(bl);
		r.amp     = AMP_W'(amp);
		return r;
	endfunction

	// Q1.16 excursion over the zero point, truncated and saturated
	function automatic logic [AMP_W-1:0] peak_amplitude(logic [SAMPLE_W-1:0] mn,
			logic [SAMPLE_W-1:0] mx, logic [SAMPLE_W-1:0] zp);
		int unsigned       up;
		int unsigned       dn;
		int unsigned       level;
		longint unsigned   q;
		up    = (mx > zp) ? int'(mx) - int'(zp) : 0;
		dn    = (zp > mn) ? int'(zp) - int'(mn) : 0;
		level = (up > dn) ? up : dn;
		if (level == 0)
			return '0;
		if (zp == 0)
			return AMP_MAX;
		q = (64'(level) << 16) / 64'(zp);
		return (q > 64'(AMP_MAX)) ? AMP_MAX : q[AMP_W-1:0];
	endfunction

	// Fold one sample into the frame; on the last one, emit and restart
	task automatic fold_sample(input logic [SAMPLE_W-1:0] s, input logic lst,
			output logic emit, output frame_stats_t r);
		if (s > track_max)
			track_max = s;
		if (s < track_min)
			track_min = s;
		if (s > zp_shadow) begin
			if (above_total < MAX_FRAME)
				above_total = above_total + 1'b1;
		end else begin
			if (below_total < MAX_FRAME)
				below_total = below_total + 1'b1;
		end
		emit = lst;
		r    = '0;
		if (lst) begin
			r.min_s   = track_min;
			r.max_s   = track_max;
			r.above_n = above_total;
			r.below_n = below_total;
			r.amp     = peak_amplitude(track_min, track_max, zp_shadow);
			track_min   = MIN_RESET;
			track_max   = MAX_RESET;
			above_total = '0;
			below_total = '0;
		end
	endtask

	task automatic check_stats(input frame_stats_t got);
		frame_stats_t exp_r;
		if (pending_stats.size() == 0) begin
			fault_count++;
			if (fault_count <= 10)
				$display("unexpected result: min %0d max %0d above %0d below %0d amp %0d",
					got.min_s, got.max_s, got.above_n, got.below_n, got.amp);
		end else begin
			exp_r = pending_stats.pop_front();
			if (got.min_s != exp_r.min_s || got.max_s != exp_r.max_s ||
					got.above_n != exp_r.above_n || got.below_n != exp_r.below_n ||
					got.amp != exp_r.amp) begin
				fault_count++;
				if (fault_count <= 10)
					$display("exp/act: min %0d/%0d max %0d/%0d above %0d/%0d below %0d/%0d amp %0d/%0d",
						exp_r.min_s, got.min_s, exp_r.max_s, got.max_s,
						exp_r.above_n, got.above_n, exp_r.below_n, got.below_n,
						exp_r.amp, got.amp);
			end
		end
	endtask

	// Track register writes, accepted samples and delivered results
	always @(posedge clk) begin
		logic         emit;
		frame_stats_t r;
		frame_stats_t got;
		sample_tag_t  tag;
		if (arst_n) begin
			if (psel && penable && pwrite && pready && (paddr >> 2) == REG_ZERO_POINT)
				zp_shadow = pwdata[SAMPLE_W-1:0];
			if (s_tvalid && s_tready) begin
				fold_sample(s_tdata[SAMPLE_W-1:0], s_tlast, emit, r);
				tag = sent_tags.pop_front();
				if (emit)
					pending_stats.push_back(tag.pinned ? tag.want : r);
			end
			if (m_tvalid && m_tready) begin
				got.min_s   = m_tdata[SAMPLE_W-1:0];
				got.max_s   = m_tdata[2*SAMPLE_W-1:SAMPLE_W];
				got.above_n = m_tdata[2*SAMPLE_W+CNT_W-1:2*SAMPLE_W];
				got.below_n = m_tdata[2*SAMPLE_W+2*CNT_W-1:2*SAMPLE_W+CNT_W];
				got.amp     = m_tdata[2*SAMPLE_W+2*CNT_W+AMP_W-1:2*SAMPLE_W+2*CNT_W];
				check_stats(got);
			end
		end
	end

	// Stall the result side at random
	always @(posedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= take_idle_pct);
	end

	// End the run if nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic set_idling(input int mode);
		case (mode)
			0: begin
				send_idle_pct = 17;
				take_idle_pct = 58;
			end
			1: begin
				send_idle_pct = 58;
				take_idle_pct = 17;
			end
			default: begin
				send_idle_pct = 0;
				take_idle_pct = 0;
			end
		endcase
	endtask

	task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic lst,
			input logic pin, input frame_stats_t want);
		sample_tag_t tag;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		tag.pinned = pin;
		tag.want   = want;
		sent_tags.push_back(tag);
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TDATA_W-SAMPLE_W){1'b0}}, smp};
		s_tlast  <= lst;
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	// Hold the stream until every result is in and the block has settled
	task automatic drain_block();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_stats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
		drain_block();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic add_sample(input int smp, input logic lst, input logic pin,
			input frame_stats_t want);
		bringup_row_t row;
		row.kind   = ROW_SAMPLE;
		row.addr   = '0;
		row.wdata  = '0;
		row.smp    = SAMPLE_W'(smp);
		row.lst    = lst;
		row.pinned = pin;
		row.want   = want;
		bringup.push_back(row);
	endtask

	task automatic add_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
		bringup_row_t row;
		row.kind   = ROW_WRITE;
		row.addr   = addr;
		row.wdata  = data;
		row.smp    = '0;
		row.lst    = 1'b0;
		row.pinned = 1'b0;
		row.want   = '0;
		bringup.push_back(row);
	endtask

	// Mostly full range, some rail values, some codes close to the zero point
	function automatic logic [SAMPLE_W-1:0] pick_sample(int zp);
		int pick;
		int v;
		pick = $urandom_range(99);
		if (pick < 10)
			return $urandom_range(1) ? '1 : '0;
		if (pick < 35) begin
			v = zp + int'($urandom_range(6)) - 3;
			if (v < 0)
				v = 0;
			if (v > 4095)
				v = 4095;
			return SAMPLE_W'(v);
		end
		return SAMPLE_W'($urandom_range(4095));
	endfunction

	initial begin
		int           phase_zp;
		int           frame_left;
		int           sent;
		int           pick;
		logic         force_long;
		bringup_row_t row;

		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Bring-up rows: reset zero point, rails, zero point extremes
		add_sample(2048, 1'b1, 1'b1, stats(2048, 2048, 0, 1, 0));
		add_sample(0,    1'b1, 1'b1, stats(0, 0, 0, 1, 65536));
		add_sample(4095, 1'b1, 1'b1, stats(4095, 4095, 1, 0, 65504));
		add_sample(4095, 1'b0, 1'b0, '0);
		add_sample(0,    1'b1, 1'b1, stats(0, 4095, 1, 1, 65536));
		add_write(ZP_ADDR, 32'hABCD_E001);
		add_sample(4095, 1'b1, 1'b1, stats(4095, 4095, 1, 0, 131071));
		add_sample(1,    1'b1, 1'b1, stats(1, 1, 0, 1, 0));
		add_sample(0,    1'b1, 1'b1, stats(0, 0, 0, 1, 65536));
		// zero point of zero, reached through the masked upper bits
		add_write(ZP_ADDR, 32'h0000_1000);
		add_sample(0,    1'b1, 1'b1, stats(0, 0, 0, 1, 0));
		add_sample(5,    1'b1, 1'b1, stats(5, 5, 1, 0, 131071));
		add_write(ZP_ADDR, 32'hFFFF_FFFF);
		add_sample(4095, 1'b1, 1'b1, stats(4095, 4095, 0, 1, 0));
		add_sample(0,    1'b1, 1'b1, stats(0, 0, 0, 1, 65536));
		// write to an unused register must leave the zero point alone
		add_write(SPARE_ADDR, 32'h0000_0007);
		add_sample(4094, 1'b1, 1'b0, '0);
		// new zero point in the middle of a frame
		add_write(ZP_ADDR, 32'h0000_0800);
		add_sample(100,  1'b0, 1'b0, '0);
		add_write(ZP_ADDR, 32'h0000_0032);
		add_sample(12'h555, 1'b0, 1'b0, '0);
		add_sample(12'hAAA, 1'b0, 1'b0, '0);
		add_sample(60,   1'b1, 1'b0, '0);

		set_idling(0);
		foreach (bringup[i]) begin
			row = bringup[i];
			if (row.kind == ROW_WRITE)
				cfg_write(row.addr, row.wdata);
			else
				send_sample(row.smp, row.lst, row.pinned, row.want);
		end

		// Random frames, one zero point per phase; frames may span phases
		frame_left = 0;
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: phase_zp = 1;
				1: phase_zp = 4095;
				2: phase_zp = 0;
				3: phase_zp = 2048;
				4: phase_zp = $urandom_range(1, 4095);
				default: phase_zp = $urandom_range(1, 30);
			endcase
			cfg_write(ZP_ADDR, ($urandom & 32'hFFFF_F000) | 32'(phase_zp));
			set_idling(ph / 2);
			force_long = (ph == 3);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if (frame_left == 0) begin
					pick = $urandom_range(99);
					if (force_long || pick < 1)
						frame_left = int'(MAX_FRAME) + $urandom_range(1, 16);
					else if (pick < 15)
						frame_left = $urandom_range(9, 40);
					else
						frame_left = $urandom_range(1, 8);
					force_long = 1'b0;
				end
				send_sample(pick_sample(phase_zp), frame_left == 1, 1'b0, '0);
				frame_left--;
				sent++;
			end
		end
		while (frame_left > 0) begin
			send_sample(pick_sample(phase_zp), frame_left == 1, 1'b0, '0);
			frame_left--;
		end

		drain_block();
		if (pending_stats.size() != 0)
			fault_count++;
		if (fault_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+sv
sv/fmmps_pkg.sv
sv/fmmps_ctrl.sv
sv/fmmps_dp.sv
sv/frame_min_max_peak_stats.sv
dv/frame_min_max_peak_stats_tb.sv
